[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the charge estimator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside of reset.
`define IEL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define IEL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/iel_pkg.sv]
// ----------------------------------------------------------------------------
// iel_pkg
// Types, codes and helper functions of the ionization energy loss estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package iel_pkg;

    // Channels of an item that take part in the average.
    localparam int NUM_CHANNELS = 4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_LEVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PILEUP_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_GAIN       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Z_OFFSET     = 2'd3;

    // Register reset values.
    localparam logic [15:0] NOISE_LEVEL_RST  = 16'd216;
    localparam logic [15:0] PILEUP_LIMIT_RST = 16'd1500;
    localparam logic [15:0] Z_GAIN_RST       = 16'd2048;
    localparam logic [15:0] Z_OFFSET_RST     = 16'hFA3D;

    // Status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_FIRED   = 3'd1;
    localparam logic [2:0] ST_ADC_PILEUP  = 3'd2;
    localparam logic [2:0] ST_FLAG_PILEUP = 3'd3;
    localparam logic [2:0] ST_NO_CHANNEL  = 3'd4;
    localparam logic [2:0] ST_NO_BETA     = 3'd5;

    // Square root is split over stages of a few steps each.
    localparam int SQRT_STEPS_PER_STAGE = 4;
    localparam int SQRT_STAGES          = 4;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] root;
    } t_sqrt;

    // One digit step of the integer square root; step 0 uses bit 30.
    function automatic t_sqrt sqrt_step(input t_sqrt d, input int step);
        t_sqrt       q;
        logic [31:0] bitv;
        logic [32:0] trial;
        bitv  = 32'(1) << (30 - 2 * step);
        trial = {1'b0, d.root} + {1'b0, bitv};
        q     = d;
        if ({1'b0, d.rem} >= trial) begin
            q.rem  = d.rem - trial[31:0];
            q.root = (d.root >> 1) + bitv;
        end else begin
            q.root = d.root >> 1;
        end
        return q;
    endfunction

    // Largest y below 2^16 with y^5 <= 2^16 * b^4, that is 2^16 * (b / 2^16)^0.8.
    function automatic logic [15:0] pow_entry(input logic [15:0] b);
        logic [16:0] lo;
        logic [16:0] hi;
        logic [16:0] mid;
        logic [95:0] m;
        logic [95:0] lim;
        logic [95:0] y5;
        lo  = '0;
        hi  = 17'd65535;
        m   = 96'(b);
        lim = (m * m * m * m) << 16;
        for (int k = 0; k < 17; k++) begin
            if (lo < hi) begin
                mid = (lo + hi + 17'd1) >> 1;
                y5  = 96'(mid);
                y5  = y5 * y5 * y5 * y5 * y5;
                if (y5 <= lim) begin
                    lo = mid;
                end else begin
                    hi = mid - 17'd1;
                end
            end
        end
        return lo[15:0];
    endfunction

endpackage

`default_nettype wire

[sv/iel_in_if.sv]
// ----------------------------------------------------------------------------
// iel_in_if
// Event channel into the estimator: valid, ready and the event fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface iel_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample_a;
    logic [15:0] sample_b;
    logic [15:0] sample_c;
    logic [15:0] sample_d;
    logic [3:0]  channel_fired;
    logic        module_fired;
    logic [15:0] pileup_sample;
    logic        pileup_flag;
    logic [15:0] velocity_ratio;
    logic        velocity_known;

    modport source (
        output valid, sample_a, sample_b, sample_c, sample_d, channel_fired,
               module_fired, pileup_sample, pileup_flag, velocity_ratio,
               velocity_known,
        input  ready
    );
    modport sink (
        input  valid, sample_a, sample_b, sample_c, sample_d, channel_fired,
               module_fired, pileup_sample, pileup_flag, velocity_ratio,
               velocity_known,
        output ready
    );
endinterface

`default_nettype wire

[sv/iel_out_if.sv]
// ----------------------------------------------------------------------------
// iel_out_if
// Result channel out of the estimator: valid, ready and the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface iel_out_if;
    logic               valid;
    logic               ready;
    logic [23:0]        energy_loss;
    logic signed [15:0] charge;
    logic [2:0]         status;
    logic [2:0]         used_channels;

    modport source (
        output valid, energy_loss, charge, status, used_channels,
        input  ready
    );
    modport sink (
        input  valid, energy_loss, charge, status, used_channels,
        output ready
    );
endinterface

`default_nettype wire

[sv/iel_sqrt_stage.sv]
// ----------------------------------------------------------------------------
// iel_sqrt_stage
// One register stage of the integer square root, a few digit steps deep.
// ----------------------------------------------------------------------------
`default_nettype none

module iel_sqrt_stage #(
    parameter int FIRST_STEP = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire iel_pkg::t_sqrt i_d,
    output iel_pkg::t_sqrt      o_q
);
    import iel_pkg::*;

    t_sqrt n_q;
    t_sqrt r_q;

    always_comb begin
        n_q = i_d;
        for (int j = 0; j < SQRT_STEPS_PER_STAGE; j++) begin
            n_q = sqrt_step(n_q, FIRST_STEP + j);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

[sv/ionization_energy_loss_charge_estimator.sv]
// Each accepted item passes through every stage register in order, and its
// result is presented from the output register of the last stage.
// Throughput: one item per cycle while the output is ready; each stage holds its
// own item and advances once the next stage has room, so bubbles are squeezed out.
// The longest stage is a 32 by 16 multiply; the power table is a synchronous ROM.
// Reset (synchronous, active low) empties the pipeline and restores registers.
// ----------------------------------------------------------------------------
// ionization_energy_loss_charge_estimator
// Averages the fired sampling channels of a detector event into an energy
// loss and estimates the charge Z = gain * beta^0.8 * sqrt(dE) + offset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ionization_energy_loss_charge_estimator #(
    parameter int POWER_TABLE_DEPTH = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [iel_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [15:0]                   i_cfg_data,
    iel_in_if.sink                             i_in,
    iel_out_if.source                          o_out
);
    import iel_pkg::*;

    // Pipeline map:
    //   stage 0: rejection checks, channel qualification, sum, count, table index
    //   stage 1: mean (divide by the count) and power table read
    //   stage 2: gain times beta power, square root operand
    //   stages 3 to 6: square root, four digit steps per stage
    //   stage 7: product of gain power and square root
    //   stage 8: offset, rounding, saturation and masking of rejected items
    localparam int NSTG     = 9;
    localparam int STG_SQ0  = 3;
    localparam int STG_PROD = 7;
    localparam int STG_OUT  = 8;
    localparam int IDX_W    = (POWER_TABLE_DEPTH > 1) ? $clog2(POWER_TABLE_DEPTH) : 1;

    // The power table is computed at elaboration and read as a ROM.
    typedef logic [15:0] t_pow_rom [POWER_TABLE_DEPTH];

    function automatic t_pow_rom build_pow_rom();
        t_pow_rom rom;
        for (int i = 0; i < POWER_TABLE_DEPTH; i++) begin
            rom[i] = pow_entry(16'((longint'(i) * 65536) / POWER_TABLE_DEPTH));
        end
        return rom;
    endfunction

    localparam t_pow_rom POW_ROM = build_pow_rom();

    // Per-item data that rides alongside the square root.
    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  cnt;
        logic [23:0] eloss;
        logic [31:0] gp;
    } t_side;

    // ---------------------------------------------------------------- config
    logic [15:0] r_noise_level;
    logic [15:0] r_pileup_limit;
    logic [15:0] r_z_gain;
    logic [15:0] r_z_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_level  <= NOISE_LEVEL_RST;
            r_pileup_limit <= PILEUP_LIMIT_RST;
            r_z_gain       <= Z_GAIN_RST;
            r_z_offset     <= Z_OFFSET_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NOISE_LEVEL:  r_noise_level  <= i_cfg_data;
                REG_PILEUP_LIMIT: r_pileup_limit <= i_cfg_data;
                REG_Z_GAIN:       r_z_gain       <= i_cfg_data;
                REG_Z_OFFSET:     r_z_offset     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------ flow control
    // A stage loads when it is empty or when the stage after it moves on.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || o_out.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= (k == 0) ? i_in.valid : r_vld[k-1];
                end
            end
        end
    end

    assign i_in.ready = w_en[0];

    // ---------------------------------------------------------- stage 0
    // Rejections are ranked: not fired, ADC pile-up, flagged pile-up, no
    // usable channel, unknown beta. The pile-up marker never enters the sum.
    logic [15:0] w_sample [4];
    logic [17:0] w_sum;
    logic [2:0]  w_cnt;
    logic [2:0]  w_status;
    logic [32:0] w_idx_prod;

    always_comb begin
        w_sample[0] = i_in.sample_a;
        w_sample[1] = i_in.sample_b;
        w_sample[2] = i_in.sample_c;
        w_sample[3] = i_in.sample_d;
        w_sum = '0;
        w_cnt = '0;
        for (int i = 0; i < 4; i++) begin
            if ((i < NUM_CHANNELS) && i_in.channel_fired[i]
                    && (w_sample[i] >= r_noise_level)) begin
                w_sum = w_sum + {2'b00, w_sample[i]};
                w_cnt = w_cnt + 3'd1;
            end
        end
        if (!i_in.module_fired) begin
            w_status = ST_NOT_FIRED;
        end else if (i_in.pileup_sample > r_pileup_limit) begin
            w_status = ST_ADC_PILEUP;
        end else if (i_in.pileup_flag) begin
            w_status = ST_FLAG_PILEUP;
        end else if (w_cnt == 3'd0) begin
            w_status = ST_NO_CHANNEL;
        end else if (!i_in.velocity_known) begin
            w_status = ST_NO_BETA;
        end else begin
            w_status = ST_OK;
        end
        // Table address is floor(beta * depth / 2^16).
        w_idx_prod = {17'b0, i_in.velocity_ratio} * 33'(POWER_TABLE_DEPTH);
    end

    logic [2:0]       r0_status;
    logic [17:0]      r0_sum;
    logic [2:0]       r0_cnt;
    logic [IDX_W-1:0] r0_idx;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_status <= w_status;
            r0_sum    <= w_sum;
            r0_cnt    <= w_cnt;
            r0_idx    <= w_idx_prod[16 +: IDX_W];
        end
    end

    // ---------------------------------------------------------- stage 1
    // The mean is sum * 256 / count. Counts of one, two and four are shifts;
    // three uses a reciprocal multiply for the whole part and the remainder
    // picks the fraction (0, 85 or 170 in 1/256 units).
    logic [35:0] w_div3_prod;
    logic [15:0] w_q3;
    logic [17:0] w_r3;
    logic [23:0] w_eloss;

    always_comb begin
        w_div3_prod = {18'b0, r0_sum} * 36'd174763;
        w_q3        = w_div3_prod[34:19];
        w_r3        = r0_sum - ({2'b00, w_q3} * 18'd3);
        case (r0_cnt)
            3'd1: w_eloss = {r0_sum[15:0], 8'b0};
            3'd2: w_eloss = {r0_sum[16:0], 7'b0};
            3'd3: w_eloss = {w_q3, 8'b0} + ((w_r3[1:0] == 2'd2) ? 24'd170
                            : (w_r3[1:0] == 2'd1) ? 24'd85 : 24'd0);
            3'd4: w_eloss = {r0_sum[17:0], 6'b0};
            default: w_eloss = '0;
        endcase
    end

    logic [2:0]  r1_status;
    logic [2:0]  r1_cnt;
    logic [23:0] r1_eloss;
    logic [15:0] r1_pow;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_status <= r0_status;
            r1_cnt    <= r0_cnt;
            r1_eloss  <= w_eloss;
            r1_pow    <= POW_ROM[r0_idx];
        end
    end

    // ---------------------------------------------------------- stage 2
    // The side data is loaded here and then shifts along with the square
    // root stages, one register per stage up to the product stage.
    t_side r_side [2:STG_PROD];
    t_sqrt r2_sq;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_side[2].status <= r1_status;
            r_side[2].cnt    <= r1_cnt;
            r_side[2].eloss  <= r1_eloss;
            r_side[2].gp     <= {16'b0, r_z_gain} * {16'b0, r1_pow};
            r2_sq.rem        <= {r1_eloss, 8'b0};
            r2_sq.root       <= '0;
        end
        for (int k = 3; k <= STG_PROD; k++) begin
            if (w_en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ----------------------------------------------------- stages 3 to 6
    // floor(sqrt(dE * 256)) gives the root directly in Q8.8.
    t_sqrt w_sq_in  [SQRT_STAGES];
    t_sqrt w_sq_out [SQRT_STAGES];

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
        assign w_sq_in[g] = (g == 0) ? r2_sq : w_sq_out[(g == 0) ? 0 : g - 1];
        iel_sqrt_stage #(
            .FIRST_STEP (g * SQRT_STEPS_PER_STAGE)
        ) u_sqrt (
            .i_clk (i_clk),
            .i_en  (w_en[STG_SQ0 + g]),
            .i_d   (w_sq_in[g]),
            .o_q   (w_sq_out[g])
        );
    end

    // ---------------------------------------------------------- stage 7
    logic [47:0] r7_prod;

    always_ff @(posedge i_clk) begin
        if (w_en[STG_PROD]) begin
            r7_prod <= {16'b0, r_side[STG_PROD-1].gp}
                     * {32'b0, w_sq_out[SQRT_STAGES-1].root[15:0]};
        end
    end

    // ---------------------------------------------------------- stage 8
    // The product has 36 fraction bits. The offset, biased by 2^15 so that the
    // sum stays positive, is added at 2^24, then half an LSB at 2^27 rounds,
    // and the top bits are the Q8.8 charge plus the bias of 2048.
    logic [48:0]        w_acc;
    logic [20:0]        w_q;
    logic signed [15:0] w_charge;
    logic [23:0]        w_out_eloss;
    logic [2:0]         w_out_cnt;

    always_comb begin
        w_acc = {1'b0, r7_prod}
              + ({33'b0, r_z_offset ^ 16'h8000} << 24)
              + (49'd1 << 27);
        w_q = w_acc[48:28];
        if (w_q >= 21'd34815) begin
            w_charge = 16'sd32767;
        end else begin
            w_charge = 16'(w_q - 21'd2048);
        end
        if (r_side[STG_PROD].status != ST_OK) begin
            w_charge = '0;
        end
        if ((r_side[STG_PROD].status == ST_OK) || (r_side[STG_PROD].status == ST_NO_BETA))
        begin
            w_out_eloss = r_side[STG_PROD].eloss;
            w_out_cnt   = r_side[STG_PROD].cnt;
        end else begin
            w_out_eloss = '0;
            w_out_cnt   = '0;
        end
    end

    logic [23:0]        r_out_eloss;
    logic signed [15:0] r_out_charge;
    logic [2:0]         r_out_status;
    logic [2:0]         r_out_cnt;

    always_ff @(posedge i_clk) begin
        if (w_en[STG_OUT]) begin
            r_out_eloss  <= w_out_eloss;
            r_out_charge <= w_charge;
            r_out_status <= r_side[STG_PROD].status;
            r_out_cnt    <= w_out_cnt;
        end
    end

    assign o_out.valid         = r_vld[STG_OUT];
    assign o_out.energy_loss   = r_out_eloss;
    assign o_out.charge        = r_out_charge;
    assign o_out.status        = r_out_status;
    assign o_out.used_channels = r_out_cnt;

    // -------------------------------------------------------- assertions
    `IEL_ASSERT(a_reject_zero, i_clk, i_rst_n,
        o_out.valid && (o_out.status != ST_OK) && (o_out.status != ST_NO_BETA)
            |-> (o_out.energy_loss == '0) && (o_out.charge == '0)
            && (o_out.used_channels == '0),
        "rejected item carries nonzero result")
    `IEL_ASSERT(a_no_beta, i_clk, i_rst_n,
        o_out.valid && (o_out.status == ST_NO_BETA)
            |-> (o_out.charge == '0) && (o_out.used_channels != '0),
        "item without beta has a charge or no channels")
    `IEL_ASSERT(a_ok_used, i_clk, i_rst_n,
        o_out.valid && (o_out.status == ST_OK) |-> (o_out.used_channels != '0),
        "accepted item averaged no channel")
    `IEL_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> (r_vld == '0),
        "pipeline not empty after reset")

endmodule

`default_nettype wire
